/* hw/rtl/msfb_pkg.sv */
// ----------------------------------------------------------------------------
// msfb_pkg
// Shared widths and constants of the motor speed frame builder: speed lane
// scaling, frame layout and CRC parameters.
// ----------------------------------------------------------------------------
package msfb_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned LaneLatency = 4;
  localparam int unsigned FrameLen = 22;
  localparam int unsigned PosWidth = $clog2(FrameLen);

  typedef logic [15:0] word_t;
  typedef logic [7:0] byte_t;
  typedef logic [PosWidth-1:0] pos_t;
  typedef word_t [NumMotors-1:0] word_arr_t;

  localparam word_t DisabledWord = 16'h4000;
  localparam logic [14:0] SpeedLimit = 15'd32000;
  localparam logic [12:0] GainNum = 13'd8191;
  localparam logic [27:0] RoundBias = 28'd8000;
  localparam int unsigned PreShift = 7;
  localparam logic [6:0] Divisor = 7'd125;
  localparam logic [14:0] RecipMul = 15'd16777;
  localparam int unsigned RecipShift = 21;

  localparam word_t CrcInit = 16'h3692;
  localparam word_t CrcPoly = 16'h8408;
  localparam byte_t FillByte = 8'hFF;

  localparam pos_t PosId = 5'd7;
  localparam pos_t PosWordsFirst = 5'd8;
  localparam pos_t PosFillFirst = 5'd16;
  localparam pos_t PosCrcLow = 5'd20;
  localparam pos_t PosCrcHigh = 5'd21;

  function automatic byte_t header_byte(input logic [2:0] idx);
    byte_t b;
    case (idx)
      3'd0: b = 8'h55;
      3'd1: b = 8'h16;
      3'd3: b = 8'h9D;
      3'd4: b = 8'hA0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/msfb_lane.sv */
// ----------------------------------------------------------------------------
// msfb_lane
// One speed lane: saturate, scale by 8191/16000 with rounding away from zero,
// pack to a 14-bit two's complement word or the disabled code. Four stages.
// ----------------------------------------------------------------------------
module msfb_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                enable_i,
  input  logic signed [15:0]  speed_i,
  output msfb_pkg::word_t     word_o
);

  logic        en1_q, en2_q, en3_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic [14:0] mag1_q, mag1_d;
  logic [15:0] abs_s;
  logic [27:0] prod2_q;
  logic [27:0] sum_s;
  logic [20:0] m3_q, m3_d;
  logic [35:0] est3_q;
  logic [14:0] q_s, qc_s, wq_s;
  logic [20:0] qd_s, rem_s;
  msfb_pkg::word_t word_q, word_d;

  assign abs_s  = speed_i[15] ? 16'(-speed_i) : 16'(speed_i);
  assign mag1_d = (abs_s > 16'(msfb_pkg::SpeedLimit)) ? msfb_pkg::SpeedLimit : abs_s[14:0];

  assign sum_s = prod2_q + msfb_pkg::RoundBias;
  assign m3_d  = sum_s[27:msfb_pkg::PreShift];

  assign q_s   = est3_q[35:msfb_pkg::RecipShift];
  assign qd_s  = 21'(q_s) * 21'(msfb_pkg::Divisor);
  assign rem_s = m3_q - qd_s;
  assign qc_s  = (rem_s >= 21'(msfb_pkg::Divisor)) ? 15'(q_s + 15'd1) : q_s;
  assign wq_s  = neg3_q ? 15'(-qc_s) : qc_s;
  assign word_d = en3_q ? {2'b00, wq_s[13:0]} : msfb_pkg::DisabledWord;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en1_q  <= 1'b0;
      en2_q  <= 1'b0;
      en3_q  <= 1'b0;
      neg1_q <= 1'b0;
      neg2_q <= 1'b0;
      neg3_q <= 1'b0;
    end else begin
      if (load_i) begin
        en1_q  <= enable_i;
        neg1_q <= speed_i[15];
      end
      en2_q  <= en1_q;
      en3_q  <= en2_q;
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag1_q <= mag1_d;
    end
    prod2_q <= 28'(mag1_q) * 28'(msfb_pkg::GainNum);
    m3_q    <= m3_d;
    est3_q  <= 36'(m3_d) * 36'(msfb_pkg::RecipMul);
    word_q  <= word_d;
  end

  assign word_o = word_q;

endmodule

/* hw/rtl/msfb_framer.sv */
// ----------------------------------------------------------------------------
// msfb_framer
// Merge stage: serializes header, id, lane words, fill and CRC into the output
// register, one beat per unstalled cycle, updating the reflected CRC bytewise.
// ----------------------------------------------------------------------------
module msfb_framer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  msfb_pkg::byte_t       responder_i,
  input  msfb_pkg::word_arr_t   words_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output msfb_pkg::byte_t       frame_byte_o,
  output logic                  last_byte_o,
  output logic                  done_o
);

  logic            active_q;
  logic            valid_q;
  logic            last_q;
  msfb_pkg::pos_t  pos_q;
  msfb_pkg::word_t crc_q;
  msfb_pkg::byte_t byte_q;
  msfb_pkg::byte_t cur_s;
  msfb_pkg::word_t crc_d;
  msfb_pkg::word_t sel_word_s;
  logic [2:0]      woff_s;
  logic            load_s;

  function automatic msfb_pkg::word_t crc_byte(input msfb_pkg::word_t c_in,
                                               input msfb_pkg::byte_t b);
    msfb_pkg::word_t c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ msfb_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  assign woff_s     = 3'(pos_q - msfb_pkg::PosWordsFirst);
  assign sel_word_s = words_i[woff_s[2:1]];

  always_comb begin
    if (pos_q < msfb_pkg::PosId) begin
      cur_s = msfb_pkg::header_byte(pos_q[2:0]);
    end else if (pos_q == msfb_pkg::PosId) begin
      cur_s = responder_i;
    end else if (pos_q < msfb_pkg::PosFillFirst) begin
      cur_s = woff_s[0] ? sel_word_s[15:8] : sel_word_s[7:0];
    end else if (pos_q < msfb_pkg::PosCrcLow) begin
      cur_s = msfb_pkg::FillByte;
    end else if (pos_q == msfb_pkg::PosCrcLow) begin
      cur_s = crc_q[7:0];
    end else begin
      cur_s = crc_q[15:8];
    end
  end

  assign crc_d  = crc_byte(crc_q, cur_s);
  assign load_s = active_q && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      pos_q    <= '0;
      crc_q    <= msfb_pkg::CrcInit;
    end else if (start_i) begin
      active_q <= 1'b1;
      pos_q    <= '0;
      crc_q    <= msfb_pkg::CrcInit;
      if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end else if (load_s) begin
      valid_q <= 1'b1;
      if (pos_q < msfb_pkg::PosCrcLow) begin
        crc_q <= crc_d;
      end
      if (pos_q == msfb_pkg::PosCrcHigh) begin
        active_q <= 1'b0;
        pos_q    <= '0;
      end else begin
        pos_q <= msfb_pkg::pos_t'(pos_q + 1'b1);
      end
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s) begin
      byte_q <= cur_s;
      last_q <= (pos_q == msfb_pkg::PosCrcHigh);
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;
  assign done_o       = load_s && (pos_q == msfb_pkg::PosCrcHigh);

endmodule

/* hw/rtl/motor_speed_frame_builder_core.sv */
// ----------------------------------------------------------------------------
// motor_speed_frame_builder_core
// A command beat is loaded into the speed lanes and moves the FSM to StCalc;
// leaving StCalc starts the framer, which registers each frame beat. No new
// command is taken (in_stall_o is high) until all 22 frame bytes are loaded.
// Reset: asynchronous active low; clears control, CRC seed and valid flags.
// ----------------------------------------------------------------------------
module motor_speed_frame_builder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         node_id_i,
  input  logic               motor0_enable_i,
  input  logic signed [15:0] motor0_speed_i,
  input  logic               motor1_enable_i,
  input  logic signed [15:0] motor1_speed_i,
  input  logic               motor2_enable_i,
  input  logic signed [15:0] motor2_speed_i,
  input  logic               motor3_enable_i,
  input  logic signed [15:0] motor3_speed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic               last_byte_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCalc = 3'b010,
    StSend = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  msfb_pkg::byte_t     responder_q;
  logic                accept_s;
  logic                start_s;
  logic                done_s;
  logic [msfb_pkg::NumMotors-1:0]        lane_en_s;
  logic signed [msfb_pkg::NumMotors-1:0][15:0] lane_speed_s;
  msfb_pkg::word_arr_t words_s;

  assign in_stall_o = (state_q != StIdle);
  assign accept_s   = in_valid_i && !in_stall_o;

  assign lane_en_s    = {motor3_enable_i, motor2_enable_i, motor1_enable_i, motor0_enable_i};
  assign lane_speed_s = {motor3_speed_i, motor2_speed_i, motor1_speed_i, motor0_speed_i};

  for (genvar g = 0; g < msfb_pkg::NumMotors; g++) begin : g_lane
    msfb_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (accept_s),
      .enable_i (lane_en_s[g]),
      .speed_i  (lane_speed_s[g]),
      .word_o   (words_s[g])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    start_s = 1'b0;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept_s) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cnt_d = 2'(cnt_q + 1'b1);
        if (cnt_q == 2'(msfb_pkg::LaneLatency - 2)) begin
          state_d = StSend;
          start_s = 1'b1;
        end
      end
      StSend: begin
        if (done_s) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      responder_q <= node_id_i;
    end
  end

  msfb_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_s),
    .responder_i  (responder_q),
    .words_i      (words_s),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .done_o       (done_s)
  );

endmodule

/* dv/motor_speed_frame_builder_checker.sv */
// ----------------------------------------------------------------------------
// motor_speed_frame_builder_checker
// Watches the command and frame channels of the motor speed frame builder.
// Each accepted command is turned into the expected 22-byte frame: header,
// node id, four scaled speed words, fill bytes and a reflected CRC16.
// Each accepted frame beat is compared against the oldest expected byte.
// ----------------------------------------------------------------------------
module motor_speed_frame_builder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  node_id_i,
  input  logic        motor0_enable_i,
  input  logic [15:0] motor0_speed_i,
  input  logic        motor1_enable_i,
  input  logic [15:0] motor1_speed_i,
  input  logic        motor2_enable_i,
  input  logic [15:0] motor2_speed_i,
  input  logic        motor3_enable_i,
  input  logic [15:0] motor3_speed_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameBytes = 22;
  localparam int SpeedSat = 32000;
  localparam int GainNum = 8191;
  localparam int GainDen = 16000;
  localparam logic [15:0] DisabledCode = 16'h4000;
  localparam logic [15:0] CrcSeedReflected = 16'h3692;
  localparam logic [15:0] CrcPolyReflected = 16'h8408;
  localparam logic [7:0] FillByte = 8'hFF;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  typedef logic [7:0] frame_bytes_t [FrameBytes];

  frame_beat_t expected_beats[$];
  int mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [15:0] scaled_speed_word(logic enable, logic [15:0] speed);
    int s;
    int mag;
    int rounded;
    if (!enable) return DisabledCode;
    s = $signed(speed);
    if (s > SpeedSat) s = SpeedSat;
    else if (s < -SpeedSat) s = -SpeedSat;
    mag = (s < 0) ? -s : s;
    rounded = (mag * GainNum + GainDen / 2) / GainDen;
    if (s < 0) rounded = -rounded;
    return 16'((16384 + rounded) & 16'h3FFF);
  endfunction

  function automatic logic [15:0] frame_crc16(frame_bytes_t bytes);
    logic [15:0] crc;
    int i;
    int k;
    crc = CrcSeedReflected;
    for (i = 0; i < FrameBytes - 2; i++) begin
      crc = crc ^ {8'h00, bytes[i]};
      for (k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPolyReflected) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic void queue_frame(logic [7:0] id, logic [3:0] enables,
                                      logic [15:0] s0, logic [15:0] s1,
                                      logic [15:0] s2, logic [15:0] s3);
    frame_bytes_t bytes;
    logic [15:0] words [4];
    logic [15:0] crc;
    frame_beat_t beat;
    int m;
    int i;
    words[0] = scaled_speed_word(enables[0], s0);
    words[1] = scaled_speed_word(enables[1], s1);
    words[2] = scaled_speed_word(enables[2], s2);
    words[3] = scaled_speed_word(enables[3], s3);
    bytes[0] = 8'h55;
    bytes[1] = 8'h16;
    bytes[2] = 8'h00;
    bytes[3] = 8'h9D;
    bytes[4] = 8'hA0;
    bytes[5] = 8'h00;
    bytes[6] = 8'h00;
    bytes[7] = id;
    for (m = 0; m < 4; m++) begin
      bytes[8 + 2 * m] = words[m][7:0];
      bytes[9 + 2 * m] = words[m][15:8];
    end
    for (i = 16; i < 20; i++) bytes[i] = FillByte;
    crc = frame_crc16(bytes);
    bytes[20] = crc[7:0];
    bytes[21] = crc[15:8];
    for (i = 0; i < FrameBytes; i++) begin
      beat.value = bytes[i];
      beat.last = (i == FrameBytes - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t beat;
    if (!rst_ni) begin
      expected_beats.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("frame_byte: expected none, got %02h", frame_byte_i);
          mismatches++;
        end else begin
          beat = expected_beats.pop_front();
          if (frame_byte_i !== beat.value) begin
            $error("frame_byte: expected %02h, got %02h", beat.value, frame_byte_i);
            mismatches++;
          end
          if (last_byte_i !== beat.last) begin
            $error("last_byte: expected %0b, got %0b", beat.last, last_byte_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        queue_frame(node_id_i,
                    {motor3_enable_i, motor2_enable_i, motor1_enable_i, motor0_enable_i},
                    motor0_speed_i, motor1_speed_i, motor2_speed_i, motor3_speed_i);
      end
      fail_count_o <= mismatches;
      pending_o <= expected_beats.size();
    end
  end

endmodule

/* dv/tb_motor_speed_frame_builder_core.sv */
// ----------------------------------------------------------------------------
// tb_motor_speed_frame_builder_core
// Drives motor commands into the frame builder: a directed set of speed
// corners, rounding halves, saturation and enable mixes, then random commands
// with random gaps on the command side and random stalls on the frame side.
// A checker beside the block predicts and compares every frame beat.
// ----------------------------------------------------------------------------
module tb_motor_speed_frame_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomCommands = 460;
  localparam int PhaseLength = 46;
  localparam int MaxIdle = 10;
  localparam int DrainCycles = 40;
  localparam int SpeedSpan = 32000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  node_id = '0;
  logic        motor0_enable = 1'b0;
  logic [15:0] motor0_speed = '0;
  logic        motor1_enable = 1'b0;
  logic [15:0] motor1_speed = '0;
  logic        motor2_enable = 1'b0;
  logic [15:0] motor2_speed = '0;
  logic        motor3_enable = 1'b0;
  logic [15:0] motor3_speed = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;

  int fail_count;
  int pending_beats;
  bit idle_on = 1'b1;
  int unsigned stall_left = 0;

  motor_speed_frame_builder_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .node_id_i       (node_id),
    .motor0_enable_i (motor0_enable),
    .motor0_speed_i  (motor0_speed),
    .motor1_enable_i (motor1_enable),
    .motor1_speed_i  (motor1_speed),
    .motor2_enable_i (motor2_enable),
    .motor2_speed_i  (motor2_speed),
    .motor3_enable_i (motor3_enable),
    .motor3_speed_i  (motor3_speed),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_byte_o    (frame_byte),
    .last_byte_o     (last_byte)
  );

  motor_speed_frame_builder_checker frame_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .node_id_i       (node_id),
    .motor0_enable_i (motor0_enable),
    .motor0_speed_i  (motor0_speed),
    .motor1_enable_i (motor1_enable),
    .motor1_speed_i  (motor1_speed),
    .motor2_enable_i (motor2_enable),
    .motor2_speed_i  (motor2_speed),
    .motor3_enable_i (motor3_enable),
    .motor3_speed_i  (motor3_speed),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .frame_byte_i    (frame_byte),
    .last_byte_i     (last_byte),
    .fail_count_o    (fail_count),
    .pending_o       (pending_beats)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    return idle_on ? $urandom_range(0, MaxIdle) : 0;
  endfunction

  // hold stall for a drawn number of cycles after each frame beat
  always @(posedge clk or negedge rst_n) begin
    int unsigned draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      draw = idle_cycles();
      stall_left <= draw;
      out_stall <= (draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  task automatic send_command(logic [7:0] id, logic [3:0] enables,
                              logic [15:0] s0, logic [15:0] s1,
                              logic [15:0] s2, logic [15:0] s3);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    node_id <= id;
    motor0_enable <= enables[0];
    motor0_speed <= s0;
    motor1_enable <= enables[1];
    motor1_speed <= s1;
    motor2_enable <= enables[2];
    motor2_speed <= s2;
    motor3_enable <= enables[3];
    motor3_speed <= s3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] random_speed();
    int pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0: return 16'($urandom);
      1: return 16'($urandom);
      2: return 16'sd32000;
      3: return -16'sd32000;
      4: return 16'($signed($urandom_range(0, 16)) + 8000 - 8);
      5: return 16'(-($signed($urandom_range(0, 16)) + 24000 - 8));
      6: return 16'($signed($urandom_range(0, 4)) - 2);
      default: return 16'($signed($urandom_range(0, 64000)) - SpeedSpan);
    endcase
  endfunction

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(8'h00, 4'b0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(8'hFF, 4'b1111, 16'sd32000, -16'sd32000, 16'h0000, 16'sd1);
    send_command(8'hA5, 4'b1111, 16'h7FFF, 16'h8000, 16'sd32001, -16'sd32001);
    send_command(8'h5A, 4'b1111, 16'sd8000, -16'sd8000, 16'sd24000, -16'sd24000);
    send_command(8'h01, 4'b1111, -16'sd1, 16'sd1, 16'sd16000, -16'sd16000);
    send_command(8'h80, 4'b0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001);
    send_command(8'h7F, 4'b0101, 16'sd31999, -16'sd31999, 16'sd2, -16'sd2);
    send_command(8'hAA, 4'b1010, 16'sd31999, -16'sd31999, 16'sd2, -16'sd2);
    send_command(8'h55, 4'b0001, 16'sd7999, 16'sd8001, -16'sd7999, -16'sd8001);
    send_command(8'h33, 4'b1000, 16'sd23999, 16'sd24001, -16'sd23999, 16'sd24001);
    send_command(8'hCC, 4'b1111, 16'h5555, 16'hAAAA, 16'h0FFF, 16'hF000);
    send_command(8'h0F, 4'b0110, 16'sd15, -16'sd16, 16'sd17, -16'sd31);

    for (n = 0; n < RandomCommands; n++) begin
      if (n % PhaseLength == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_command(8'($urandom), 4'($urandom), random_speed(), random_speed(),
                   random_speed(), random_speed());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/msfb_pkg.sv
hw/rtl/msfb_lane.sv
hw/rtl/msfb_framer.sv
hw/rtl/motor_speed_frame_builder_core.sv
dv/motor_speed_frame_builder_checker.sv
dv/tb_motor_speed_frame_builder_core.sv
